// ----- sv/bfr_pkg.sv -----
// ----------------------------------------------------------------------------
// bfr_pkg
// Types and constants shared by the bitmap font text renderer modules.
// ----------------------------------------------------------------------------
package bfr_pkg;

    // Command codes of an input beat
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_CHAR  = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_GLYPH_WIDTH   = 3'd0;
    localparam logic [2:0] CFG_GLYPH_HEIGHT  = 3'd1;
    localparam logic [2:0] CFG_SCREEN_WIDTH  = 3'd2;
    localparam logic [2:0] CFG_SCREEN_HEIGHT = 3'd3;
    localparam logic [2:0] CFG_FORE_COLOR    = 3'd4;
    localparam logic [2:0] CFG_BACK_COLOR    = 3'd5;

    // Result kinds
    localparam logic KIND_WINDOW = 1'b0;
    localparam logic KIND_ROW    = 1'b1;

    // Character codes with a meaning of their own
    localparam logic [7:0] CODE_END   = 8'd0;
    localparam logic [7:0] CODE_SPACE = 8'd32;

    // Glyph address: (code - first code) * height + row, at most 8191
    localparam int GLYPH_ADDR_W = 13;
    // Wide enough to compare any glyph or load address with the store depth
    localparam int CMP_ADDR_W   = 17;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [11:0] font_address;
        logic [15:0] font_word;
        logic [8:0]  start_col;
        logic [8:0]  start_row;
        logic [7:0]  char_code;
    } t_in_item;

    typedef struct packed {
        logic        item_kind;
        logic [8:0]  win_left;
        logic [8:0]  win_top;
        logic [9:0]  win_right;
        logic [9:0]  win_bottom;
        logic [15:0] row_mask;
        logic [15:0] on_color;
        logic [15:0] off_color;
        logic        last;
    } t_out_item;

    // One glyph to draw, handed from the front to the back
    typedef struct packed {
        logic [8:0]              left;
        logic [8:0]              top;
        logic [9:0]              right;
        logic [9:0]              bottom;
        logic [GLYPH_ADDR_W-1:0] base;
        logic [5:0]              height;
        logic [15:0]             fore;
        logic [15:0]             back;
    } t_job;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

// ----- sv/bfr_ram.sv -----
// ----------------------------------------------------------------------------
// bfr_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bfr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    // Write when enabled, read every cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/bfr_queue.sv -----
// ----------------------------------------------------------------------------
// bfr_queue
// Two-entry job queue between the layout front and the drawing back.
// ----------------------------------------------------------------------------
module bfr_queue
    import bfr_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_job          i_push_job,
    input  logic          i_pop,
    output t_job          o_head,
    output t_queue_status o_status
);

    t_job       r_entry [0:1];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign do_push = i_push && (r_count != 2'd2);
    assign do_pop  = i_pop && (r_count != 2'd0);

    // Store pushed job
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wptr] <= i_push_job;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wptr <= ~r_wptr;
            end
            if (do_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_head         = r_entry[r_rptr];
    assign o_status.full  = (r_count == 2'd2);
    assign o_status.empty = (r_count == 2'd0);

endmodule

// ----- sv/bfr_front.sv -----
// ----------------------------------------------------------------------------
// bfr_front
// Accepts input beats, holds configuration, cursor and stop flag, writes the
// font store and lays out each character into a drawing job.
// ----------------------------------------------------------------------------
module bfr_front
    import bfr_pkg::*;
#(
    parameter int FONT_WORDS = 4096,
    parameter int FIRST_CODE = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [2:0]                    i_cfg_index,
    input  logic [15:0]                   i_cfg_data,
    input  logic                          i_in_valid,
    input  t_in_item                      i_in_data,
    output logic                          o_in_stall,
    input  t_queue_status                 i_queue_status,
    input  logic                          i_back_busy,
    output logic                          o_push,
    output t_job                          o_push_job,
    output logic                          o_font_we,
    output logic [$clog2(FONT_WORDS)-1:0] o_font_waddr,
    output logic [15:0]                   o_font_wdata
);

    localparam int AW = $clog2(FONT_WORDS);

    logic [4:0]  r_glyph_w;
    logic [5:0]  r_glyph_h;
    logic [8:0]  r_screen_w;
    logic [8:0]  r_screen_h;
    logic [15:0] r_fore;
    logic [15:0] r_back;
    logic [8:0]  r_col;
    logic [8:0]  r_row;
    logic        r_halted;
    logic [8:0]  n_col;
    logic [8:0]  n_row;
    logic        n_halted;

    logic [4:0]            w;
    logic [5:0]            h;
    logic [9:0]            col_sum;
    logic                  wrap;
    logic [9:0]            nrow;
    logic [10:0]           nrow_next;
    logic                  bottom_hit;
    logic [8:0]            col_eff;
    logic [8:0]            row_eff;
    logic [9:0]            adv_col;
    logic [7:0]            code_off;
    logic [13:0]           base_full;
    logic [CMP_ADDR_W-1:0] load_addr;
    logic                  accept;
    logic                  is_char;

    // Clamp glyph size to its legal range
    always_comb begin
        if (r_glyph_w == 5'd0) begin
            w = 5'd1;
        end else if (r_glyph_w > 5'd16) begin
            w = 5'd16;
        end else begin
            w = r_glyph_w;
        end
        if (r_glyph_h == 6'd0) begin
            h = 6'd1;
        end else if (r_glyph_h > 6'd32) begin
            h = 6'd32;
        end else begin
            h = r_glyph_h;
        end
    end

    // Wrap and bottom tests
    assign col_sum    = {1'b0, r_col} + 10'(w);
    assign wrap       = (col_sum >= {1'b0, r_screen_w});
    assign nrow       = {1'b0, r_row} + 10'(h);
    assign nrow_next  = {1'b0, nrow} + 11'(h);
    assign bottom_hit = (nrow_next >= {2'b00, r_screen_h});
    assign col_eff    = wrap ? 9'd0 : r_col;
    assign row_eff    = wrap ? nrow[8:0] : r_row;
    assign adv_col    = {1'b0, col_eff} + 10'(w);

    // Glyph window and font base address
    assign code_off  = i_in_data.char_code - 8'(FIRST_CODE);
    assign base_full = 14'(code_off) * 14'(h);

    assign o_push_job.left   = col_eff;
    assign o_push_job.top    = row_eff;
    assign o_push_job.right  = {1'b0, col_eff} + 10'(w) - 10'd1;
    assign o_push_job.bottom = {1'b0, row_eff} + 10'(h) - 10'd1;
    assign o_push_job.base   = base_full[GLYPH_ADDR_W-1:0];
    assign o_push_job.height = h;
    assign o_push_job.fore   = r_fore;
    assign o_push_job.back   = r_back;

    // Hold loads until drawing has read all it needs; hold characters on a full queue
    always_comb begin
        case (i_in_data.cmd)
            CMD_LOAD: o_in_stall = i_back_busy || !i_queue_status.empty;
            CMD_CHAR: o_in_stall = i_queue_status.full;
            default:  o_in_stall = 1'b0;
        endcase
    end

    assign accept  = i_in_valid && !o_in_stall;
    assign is_char = accept && (i_in_data.cmd == CMD_CHAR) && !r_halted;

    // Font store write
    assign load_addr    = CMP_ADDR_W'(i_in_data.font_address);
    assign o_font_we    = accept && (i_in_data.cmd == CMD_LOAD)
                          && (load_addr < CMP_ADDR_W'(FONT_WORDS));
    assign o_font_waddr = load_addr[AW-1:0];
    assign o_font_wdata = i_in_data.font_word;

    // Cursor, stop flag and job push
    always_comb begin
        n_col    = r_col;
        n_row    = r_row;
        n_halted = r_halted;
        o_push   = 1'b0;
        if (accept && (i_in_data.cmd == CMD_START)) begin
            n_col    = i_in_data.start_col;
            n_row    = i_in_data.start_row;
            n_halted = 1'b0;
        end else if (is_char) begin
            if (i_in_data.char_code == CODE_END) begin
                n_halted = 1'b1;
            end else if (i_in_data.char_code >= 8'(FIRST_CODE)) begin
                n_col = col_eff;
                n_row = row_eff;
                if (wrap && bottom_hit) begin
                    n_halted = 1'b1;
                end else if (!(wrap && (i_in_data.char_code == CODE_SPACE))) begin
                    o_push = 1'b1;
                    n_col  = adv_col[8:0];
                end
            end
        end
    end

    // Registers: configuration, cursor, stop flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glyph_w  <= 5'd7;
            r_glyph_h  <= 6'd10;
            r_screen_w <= 9'd240;
            r_screen_h <= 9'd240;
            r_fore     <= 16'hFFFF;
            r_back     <= 16'h0000;
            r_col      <= 9'd0;
            r_row      <= 9'd0;
            r_halted   <= 1'b0;
        end else begin
            r_col    <= n_col;
            r_row    <= n_row;
            r_halted <= n_halted;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_GLYPH_WIDTH:   r_glyph_w  <= i_cfg_data[4:0];
                    CFG_GLYPH_HEIGHT:  r_glyph_h  <= i_cfg_data[5:0];
                    CFG_SCREEN_WIDTH:  r_screen_w <= i_cfg_data[8:0];
                    CFG_SCREEN_HEIGHT: r_screen_h <= i_cfg_data[8:0];
                    CFG_FORE_COLOR:    r_fore     <= i_cfg_data;
                    CFG_BACK_COLOR:    r_back     <= i_cfg_data;
                    default:           r_fore     <= r_fore;
                endcase
            end
        end
    end

endmodule

// ----- sv/bfr_back.sv -----
// ----------------------------------------------------------------------------
// bfr_back
// Draws queued glyph jobs: one window beat, then one beat per glyph row read
// from the font store, through a registered output stage.
// ----------------------------------------------------------------------------
module bfr_back
    import bfr_pkg::*;
#(
    parameter int FONT_WORDS = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_job                          i_head,
    input  t_queue_status                 i_queue_status,
    output logic                          o_pop,
    output logic                          o_busy,
    output logic [$clog2(FONT_WORDS)-1:0] o_font_raddr,
    input  logic [15:0]                   i_font_rdata,
    output logic                          o_out_valid,
    output t_out_item                     o_out_data,
    input  logic                          i_out_stall
);

    localparam int AW = $clog2(FONT_WORDS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WIN  = 2'd1;
    localparam logic [1:0] ST_ROWS = 2'd2;

    logic [1:0]  r_state;
    logic [1:0]  n_state;
    t_job        r_job;
    t_job        n_job;
    logic [4:0]  r_idx;
    logic [4:0]  n_idx;
    logic        r_out_valid;
    logic        n_out_valid;
    t_out_item   r_out;
    t_out_item   n_out;

    logic                    out_free;
    logic                    last_row;
    logic [GLYPH_ADDR_W-1:0] cur_addr;
    logic                    cur_in_range;
    logic [GLYPH_ADDR_W-1:0] rd_sum;
    logic [CMP_ADDR_W-1:0]   rd_addr;

    assign out_free = !r_out_valid || !i_out_stall;
    assign last_row = ({1'b0, r_idx} == (r_job.height - 6'd1));

    // The read data always belongs to the registered job and row index
    assign cur_addr     = r_job.base + GLYPH_ADDR_W'(r_idx);
    assign cur_in_range = (CMP_ADDR_W'(cur_addr) < CMP_ADDR_W'(FONT_WORDS));

    // Sequencer: window beat, then glyph rows
    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_idx       = r_idx;
        o_pop       = 1'b0;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        case (r_state)
            ST_IDLE: begin
                if (!i_queue_status.empty) begin
                    o_pop   = 1'b1;
                    n_job   = i_head;
                    n_idx   = 5'd0;
                    n_state = ST_WIN;
                end
            end
            ST_WIN: begin
                if (out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.item_kind  = KIND_WINDOW;
                    n_out.win_left   = r_job.left;
                    n_out.win_top    = r_job.top;
                    n_out.win_right  = r_job.right;
                    n_out.win_bottom = r_job.bottom;
                    n_out.row_mask   = 16'd0;
                    n_out.on_color   = 16'd0;
                    n_out.off_color  = 16'd0;
                    n_out.last       = 1'b0;
                    n_state          = ST_ROWS;
                end
            end
            ST_ROWS: begin
                if (out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.item_kind  = KIND_ROW;
                    n_out.win_left   = r_job.left;
                    n_out.win_top    = r_job.top;
                    n_out.win_right  = r_job.right;
                    n_out.win_bottom = r_job.bottom;
                    n_out.row_mask   = cur_in_range ? i_font_rdata : 16'd0;
                    n_out.on_color   = r_job.fore;
                    n_out.off_color  = r_job.back;
                    n_out.last       = last_row;
                    if (last_row) begin
                        if (!i_queue_status.empty) begin
                            o_pop   = 1'b1;
                            n_job   = i_head;
                            n_idx   = 5'd0;
                            n_state = ST_WIN;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end else begin
                        n_idx = r_idx + 5'd1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Fetch the row that the next cycle will hold
    assign rd_sum       = n_job.base + GLYPH_ADDR_W'(n_idx);
    assign rd_addr      = CMP_ADDR_W'(rd_sum);
    assign o_font_raddr = rd_addr[AW-1:0];

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_idx <= n_idx;
        r_out <= n_out;
    end

    assign o_busy      = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- sv/bitmap_font_text_renderer_top.sv -----
// ----------------------------------------------------------------------------
// bitmap_font_text_renderer_top
// Lays out text in a bitmap font: window and glyph row beats per character.
// ----------------------------------------------------------------------------
// A start beat is never held. A drawn character gives one window beat and then
// one beat per glyph row; when drawing was idle, its job is first taken from
// the queue in the idle state. Row words are read from the font memory's single
// read port, one per cycle while the output is not stalled. The front lays
// out characters ahead of drawing through a two-entry job queue; a font load
// waits until all queued and running glyphs are drawn, so it never changes a
// glyph still to be read. Characters that give no beats (end of string,
// control codes, skipped spaces, stops) push no job. The font memory has no
// reset; a row never loaded reads as anything.
module bitmap_font_text_renderer_top
    import bfr_pkg::*;
#(
    parameter int FONT_WORDS = 4096,
    parameter int FIRST_CODE = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    input  t_in_item    i_in_data,
    output logic        o_in_stall,
    output logic        o_out_valid,
    output t_out_item   o_out_data,
    input  logic        i_out_stall
);

    localparam int AW = $clog2(FONT_WORDS);

    t_queue_status   queue_status;
    t_job            push_job;
    t_job            head_job;
    logic            push;
    logic            pop;
    logic            back_busy;
    logic            font_we;
    logic [AW-1:0]   font_waddr;
    logic [15:0]     font_wdata;
    logic [AW-1:0]   font_raddr;
    logic [15:0]     font_rdata;

    bfr_front #(
        .FONT_WORDS (FONT_WORDS),
        .FIRST_CODE (FIRST_CODE)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_data      (i_in_data),
        .o_in_stall     (o_in_stall),
        .i_queue_status (queue_status),
        .i_back_busy    (back_busy),
        .o_push         (push),
        .o_push_job     (push_job),
        .o_font_we      (font_we),
        .o_font_waddr   (font_waddr),
        .o_font_wdata   (font_wdata)
    );

    bfr_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_job (push_job),
        .i_pop      (pop),
        .o_head     (head_job),
        .o_status   (queue_status)
    );

    bfr_ram #(
        .WIDTH (16),
        .DEPTH (FONT_WORDS)
    ) u_font_ram (
        .i_clk   (i_clk),
        .i_we    (font_we),
        .i_waddr (font_waddr),
        .i_wdata (font_wdata),
        .i_raddr (font_raddr),
        .o_rdata (font_rdata)
    );

    bfr_back #(
        .FONT_WORDS (FONT_WORDS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head_job),
        .i_queue_status (queue_status),
        .o_pop          (pop),
        .o_busy         (back_busy),
        .o_font_raddr   (font_raddr),
        .i_font_rdata   (font_rdata),
        .o_out_valid    (o_out_valid),
        .o_out_data     (o_out_data),
        .i_out_stall    (i_out_stall)
    );

endmodule
